// ===== rtl/p224mm_pkg.sv =====
package p224mm_pkg;

   localparam int DigitW    = 32;
   localparam int NumDigits = 8;
   localparam int OperandW  = 224;
   localparam int OperandDigits = OperandW / DigitW;
   localparam int AccW      = 258;
   // Between digit steps the accumulator never exceeds this many bits.
   localparam int AccBound  = 226;

   localparam logic [OperandW-1:0] Prime =
      224'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_00000000_00000000_00000001;

   typedef logic [OperandW-1:0] operand_type;
   typedef logic [AccW-1:0]     acc_type;

   typedef struct packed {
      logic [31:0] a_limb3;
      logic [63:0] a_limb2;
      logic [63:0] a_limb1;
      logic [63:0] a_limb0;
      logic [31:0] b_limb3;
      logic [63:0] b_limb2;
      logic [63:0] b_limb1;
      logic [63:0] b_limb0;
   } req_type;

   typedef struct packed {
      logic [31:0] product_limb3;
      logic [63:0] product_limb2;
      logic [63:0] product_limb1;
      logic [63:0] product_limb0;
   } rsp_type;

endpackage

// ===== rtl/p224mm_digit.sv =====
module p224mm_digit import p224mm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        valid_in,
   input  operand_type a_in,
   input  operand_type b_in,
   input  acc_type     acc_in,
   output logic        valid_out,
   output operand_type a_out,
   output operand_type b_out,
   output acc_type     acc_out
);

   logic              v1_ff, v2_ff, v3_ff;
   logic [63:0]       pp_ff [OperandDigits];
   logic [63:0]       pp_in [OperandDigits];
   operand_type       a1_ff, b1_ff, a2_ff, b2_ff, a3_ff, b3_ff;
   acc_type           acc1_ff, sum_ff, sum_in, acc3_ff, acc3_in, red;
   logic [255:0]      even_vec, odd_vec;
   logic [DigitW-1:0] m_digit;
   acc_type           m_ext;

   // Stage one: digit of a times each digit of b.
   always_comb begin
      for (int k = 0; k < OperandDigits; k++) begin
         pp_in[k] = 64'(a_in[DigitW-1:0]) * 64'(b_in[k*DigitW +: DigitW]);
      end
   end

   // Stage two: fold the partial products into the accumulator.
   assign even_vec = {pp_ff[6], pp_ff[4], pp_ff[2], pp_ff[0]};
   assign odd_vec  = {32'd0, pp_ff[5], pp_ff[3], pp_ff[1], 32'd0};
   assign sum_in   = acc1_ff + AccW'(even_vec) + AccW'(odd_vec);

   // Stage three: since -1/p is -1 mod 2^32, the quotient digit is the negated low digit,
   // and m*p = m*2^224 - m*2^96 + m needs only shifts.
   assign m_digit = ~sum_ff[DigitW-1:0] + 32'd1;
   assign m_ext   = AccW'(m_digit);
   assign red     = sum_ff + (m_ext << (7*DigitW)) + m_ext - (m_ext << (3*DigitW));
   assign acc3_in = red >> DigitW;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff   <= pp_in;
      a1_ff   <= a_in >> DigitW;
      b1_ff   <= b_in;
      acc1_ff <= acc_in;
      a2_ff   <= a1_ff;
      b2_ff   <= b1_ff;
      sum_ff  <= sum_in;
      a3_ff   <= a2_ff;
      b3_ff   <= b2_ff;
      acc3_ff <= acc3_in;
   end

   assign valid_out = v3_ff;
   assign a_out     = a3_ff;
   assign b_out     = b3_ff;
   assign acc_out   = acc3_ff;

`ifndef NO_ASSERTIONS
   acc_bounded: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (acc3_ff[AccW-1:AccBound] == '0))
      else $error("accumulator grew past its bound");
   step_latency: assert property (@(posedge clock) disable iff (reset)
      valid_in |-> ##3 valid_out)
      else $error("digit step lost a word");
`endif

endmodule

// ===== rtl/p224mm_final.sv =====
module p224mm_final import p224mm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    valid_in,
   input  acc_type acc_in,
   output logic    valid_out,
   output rsp_type rsp_out
);

   logic [AccW:0]     diff;
   logic [OperandW-1:0] result;
   logic              valid_ff;
   rsp_type           rsp_ff;

   assign diff   = {1'b0, acc_in} - (AccW+1)'(Prime);
   // A borrow means the accumulator was already below p.
   assign result = diff[AccW] ? acc_in[OperandW-1:0] : diff[OperandW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_type'(result);
   end

   assign valid_out = valid_ff;
   assign rsp_out   = rsp_ff;

`ifndef NO_ASSERTIONS
   out_follows_in: assert property (@(posedge clock) disable iff (reset)
      valid_out |-> $past(valid_in))
      else $error("result word without a source");
`endif

endmodule

// ===== rtl/p224_montgomery_multiply.sv =====
// Each accepted start passes through eight 32-bit digit steps (partial products,
// accumulate, reduce) and a registered final subtraction of p before rsp_valid.
// Throughput: one word per cycle; busy is always low and the pipeline never stalls.
// Reset clears only the valid bits of the pipeline; words in flight are dropped.
// Results appear for one cycle and cannot be held off by the receiver.
module p224_montgomery_multiply import p224mm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic        valid_chain [NumDigits+1];
   operand_type a_chain     [NumDigits+1];
   operand_type b_chain     [NumDigits+1];
   acc_type     acc_chain   [NumDigits+1];

   assign busy           = 1'b0;
   assign valid_chain[0] = start;
   assign a_chain[0]     = {req_data.a_limb3, req_data.a_limb2, req_data.a_limb1,
                            req_data.a_limb0};
   assign b_chain[0]     = {req_data.b_limb3, req_data.b_limb2, req_data.b_limb1,
                            req_data.b_limb0};
   assign acc_chain[0]   = '0;

   for (genvar i = 0; i < NumDigits; i++) begin : g_digit
      p224mm_digit u_digit (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (valid_chain[i]),
         .a_in      (a_chain[i]),
         .b_in      (b_chain[i]),
         .acc_in    (acc_chain[i]),
         .valid_out (valid_chain[i+1]),
         .a_out     (a_chain[i+1]),
         .b_out     (b_chain[i+1]),
         .acc_out   (acc_chain[i+1])
      );
   end

   p224mm_final u_final (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (valid_chain[NumDigits]),
      .acc_in    (acc_chain[NumDigits]),
      .valid_out (rsp_valid),
      .rsp_out   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !reset, 25))
      else $error("result word without a start");
   no_lost_rsp: assert property (@(posedge clock) disable iff (reset)
      start |-> ##25 rsp_valid)
      else $error("accepted word produced no result");
   never_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> !busy)
      else $error("pipeline reported busy");
`endif

endmodule
